@@ rtl/core/cra_pkg.sv @@
`default_nettype none

package cra_pkg;

   localparam int unsigned DATA_W = 16;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_COMPACT = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_NO_SPACE  = 3'd1,
      STS_DUP       = 3'd2,
      STS_NO_HOLE   = 3'd3,
      STS_NOT_FOUND = 3'd4,
      STS_FULL      = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      CSR_MEMORY_SIZE = 1'd0,
      CSR_FIT_MODE    = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_FREE_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_COMPACT,
      S_INSERT,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   region_id;
      logic [DATA_W-1:0]   region_size;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   block_start;
      logic [DATA_W-1:0]   block_end;
      logic [DATA_W-1:0]   free_total;
   } rsp_type;

   typedef struct packed {
      logic [DATA_W-1:0]   id;
      logic [DATA_W-1:0]   start;
      logic [DATA_W-1:0]   stop;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/core/contiguous_region_allocator_core.sv @@
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | cra_pkg::req_type
// rsp     | out       | rsp_valid / rsp_ready  | cra_pkg::rsp_type
// csr     | in        | csr_we                 | csr_index, csr_wdata
//
// One transaction at a time; req_ready is high only while idle.
// The sequencer walks the entry table (one read, one write a cycle) one entry
// per cycle for allocate, free and compact.
// Reset empties the table and zeroes memory_size; a memory_size write also empties the table.
// The response register holds until rsp_ready; no new request is taken meanwhile.
`default_nettype none

module contiguous_region_allocator_core #(
   parameter int unsigned MAX_BLOCKS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cra_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cra_pkg::rsp_type       rsp_data,
   input  wire logic              csr_we,
   input  wire logic [0:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   localparam int unsigned IW = $clog2(MAX_BLOCKS);
   localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned DW = cra_pkg::DATA_W;

   cra_pkg::entry_type mem [MAX_BLOCKS];
   cra_pkg::entry_type rd_data_ff;

   cra_pkg::state_type state_ff, state_in;
   cra_pkg::req_type   cur_ff, cur_in;
   cra_pkg::rsp_type   rsp_ff, rsp_in;
   logic [IW-1:0] iss_ptr_ff, iss_ptr_in;
   logic          iss_act_ff, iss_act_in;
   logic          ev_vld_ff, ev_vld_in;
   logic [IW-1:0] ev_idx_ff, ev_idx_in;
   logic [DW-1:0] prev_ff, prev_in;
   logic          found_ff, found_in;
   logic          dup_ff, dup_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic [DW-1:0] best_size_ff, best_size_in;
   logic [DW-1:0] best_lo_ff, best_lo_in;
   logic [DW-1:0] fs_ff, fs_in;
   logic [DW-1:0] fe_ff, fe_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] free_ff, free_in;
   logic [DW-1:0] msize_ff;
   logic          fit_ff;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   cra_pkg::entry_type wr_data;

   logic [IW-1:0] cnt_last;
   logic [IW-1:0] stop_idx;
   logic [DW-1:0] hsize, fin_size, len;
   logic          hole_fit, fin_fit;

   assign cnt_last  = IW'(cnt_ff - CW'(1));
   assign stop_idx  = (state_ff == cra_pkg::S_SHIFT_UP) ? tgt_ff : cnt_last;
   assign hsize     = rd_data_ff.start - prev_ff;
   assign hole_fit  = (rd_data_ff.start >= prev_ff) && (cur_ff.region_size <= hsize) &&
                      (!found_ff || (fit_ff && hsize < best_size_ff));
   assign fin_size  = msize_ff - prev_ff;
   assign fin_fit   = (msize_ff >= prev_ff) && (cur_ff.region_size <= fin_size) &&
                      (!found_ff || (fit_ff && fin_size < best_size_ff));
   assign len       = (rd_data_ff.stop >= rd_data_ff.start) ?
                      rd_data_ff.stop - rd_data_ff.start : '0;

   assign req_ready = (state_ff == cra_pkg::S_IDLE);
   assign rsp_valid = (state_ff == cra_pkg::S_RESP);
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic loop_st;
      logic done;
      state_in     = state_ff;
      cur_in       = cur_ff;
      rsp_in       = rsp_ff;
      iss_ptr_in   = iss_ptr_ff;
      iss_act_in   = iss_act_ff;
      ev_vld_in    = 1'b0;
      ev_idx_in    = iss_ptr_ff;
      prev_in      = prev_ff;
      found_in     = found_ff;
      dup_in       = dup_ff;
      tgt_in       = tgt_ff;
      best_size_in = best_size_ff;
      best_lo_in   = best_lo_ff;
      fs_in        = fs_ff;
      fe_in        = fe_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      wr_en        = 1'b0;
      wr_addr      = ev_idx_ff;
      wr_data      = rd_data_ff;

      loop_st = (state_ff == cra_pkg::S_ALLOC_SCAN) || (state_ff == cra_pkg::S_FREE_SCAN) ||
                (state_ff == cra_pkg::S_SHIFT_UP) || (state_ff == cra_pkg::S_SHIFT_DOWN) ||
                (state_ff == cra_pkg::S_COMPACT);
      done    = !iss_act_ff && !ev_vld_ff;

      // read issue stage: one table read per cycle
      if (loop_st && iss_act_ff) begin
         ev_vld_in  = 1'b1;
         iss_act_in = (iss_ptr_ff != stop_idx);
         iss_ptr_in = (state_ff == cra_pkg::S_SHIFT_UP) ? iss_ptr_ff - IW'(1)
                                                        : iss_ptr_ff + IW'(1);
      end

      case (state_ff)
         cra_pkg::S_IDLE: begin
            if (req_valid) begin
               cur_in     = req_data;
               iss_ptr_in = '0;
               iss_act_in = (cnt_ff != '0);
               prev_in    = '0;
               found_in   = 1'b0;
               dup_in     = 1'b0;
               rsp_in     = '{status: cra_pkg::STS_OK, block_start: '0, block_end: '0,
                              free_total: free_ff};
               case (req_data.op)
                  cra_pkg::OP_ALLOC: begin
                     if (req_data.region_size > free_ff) begin
                        rsp_in.status = cra_pkg::STS_NO_SPACE;
                        state_in      = cra_pkg::S_RESP;
                     end else begin
                        state_in = cra_pkg::S_ALLOC_SCAN;
                     end
                  end
                  cra_pkg::OP_FREE:    state_in = cra_pkg::S_FREE_SCAN;
                  cra_pkg::OP_COMPACT: state_in = cra_pkg::S_COMPACT;
                  default:             state_in = cra_pkg::S_RESP;
               endcase
            end
         end
         cra_pkg::S_ALLOC_SCAN: begin
            if (ev_vld_ff) begin
               if (rd_data_ff.id == cur_ff.region_id) dup_in = 1'b1;
               if (hole_fit) begin
                  found_in     = 1'b1;
                  tgt_in       = ev_idx_ff;
                  best_size_in = hsize;
                  best_lo_in   = prev_ff;
               end
               prev_in = rd_data_ff.stop;
            end else if (done) begin
               // last hole runs from the top block to memory_size
               if (fin_fit) begin
                  tgt_in     = cnt_last + IW'(1);
                  best_lo_in = prev_ff;
               end
               if (dup_ff) begin
                  rsp_in.status = cra_pkg::STS_DUP;
                  state_in      = cra_pkg::S_RESP;
               end else if (cnt_ff == CW'(MAX_BLOCKS)) begin
                  rsp_in.status = cra_pkg::STS_FULL;
                  state_in      = cra_pkg::S_RESP;
               end else if (!found_ff && !fin_fit) begin
                  rsp_in.status = cra_pkg::STS_NO_HOLE;
                  state_in      = cra_pkg::S_RESP;
               end else begin
                  iss_ptr_in = cnt_last;
                  iss_act_in = fin_fit ? 1'b0 : (CW'(tgt_ff) != cnt_ff);
                  state_in   = cra_pkg::S_SHIFT_UP;
               end
            end
         end
         cra_pkg::S_SHIFT_UP: begin
            if (ev_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = ev_idx_ff + IW'(1);
            end else if (done) begin
               state_in = cra_pkg::S_INSERT;
            end
         end
         cra_pkg::S_INSERT: begin
            wr_en    = 1'b1;
            wr_addr  = tgt_ff;
            wr_data  = '{id: cur_ff.region_id, start: best_lo_ff,
                         stop: best_lo_ff + cur_ff.region_size};
            cnt_in   = cnt_ff + CW'(1);
            free_in  = free_ff - cur_ff.region_size;
            rsp_in   = '{status: cra_pkg::STS_OK, block_start: best_lo_ff,
                         block_end: best_lo_ff + cur_ff.region_size,
                         free_total: free_ff - cur_ff.region_size};
            state_in = cra_pkg::S_RESP;
         end
         cra_pkg::S_FREE_SCAN: begin
            if (ev_vld_ff) begin
               if (!found_ff && rd_data_ff.id == cur_ff.region_id) begin
                  found_in = 1'b1;
                  tgt_in   = ev_idx_ff;
                  fs_in    = rd_data_ff.start;
                  fe_in    = rd_data_ff.stop;
               end
            end else if (done) begin
               if (!found_ff) begin
                  rsp_in.status = cra_pkg::STS_NOT_FOUND;
                  state_in      = cra_pkg::S_RESP;
               end else begin
                  if (fe_ff >= fs_ff) free_in = free_ff + (fe_ff - fs_ff);
                  iss_ptr_in = tgt_ff + IW'(1);
                  iss_act_in = (CW'(tgt_ff) + CW'(1) < cnt_ff);
                  state_in   = cra_pkg::S_SHIFT_DOWN;
               end
            end
         end
         cra_pkg::S_SHIFT_DOWN: begin
            if (ev_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = ev_idx_ff - IW'(1);
            end else if (done) begin
               cnt_in   = cnt_ff - CW'(1);
               rsp_in   = '{status: cra_pkg::STS_OK, block_start: fs_ff, block_end: fe_ff,
                            free_total: free_ff};
               state_in = cra_pkg::S_RESP;
            end
         end
         cra_pkg::S_COMPACT: begin
            if (ev_vld_ff) begin
               wr_en         = 1'b1;
               wr_data.start = prev_ff;
               wr_data.stop  = prev_ff + len;
               prev_in       = prev_ff + len;
            end else if (done) begin
               state_in = cra_pkg::S_RESP;
            end
         end
         cra_pkg::S_RESP: begin
            if (rsp_ready) state_in = cra_pkg::S_IDLE;
         end
         default: state_in = cra_pkg::S_IDLE;
      endcase

      // a memory_size write empties the table
      if (csr_we && (cra_pkg::csr_index_type'(csr_index) == cra_pkg::CSR_MEMORY_SIZE)) begin
         cnt_in  = '0;
         free_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[iss_ptr_ff];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rsp_ff       <= rsp_in;
      iss_ptr_ff   <= iss_ptr_in;
      ev_idx_ff    <= ev_idx_in;
      prev_ff      <= prev_in;
      found_ff     <= found_in;
      dup_ff       <= dup_in;
      tgt_ff       <= tgt_in;
      best_size_ff <= best_size_in;
      best_lo_ff   <= best_lo_in;
      fs_ff        <= fs_in;
      fe_ff        <= fe_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cra_pkg::S_IDLE;
         iss_act_ff <= 1'b0;
         ev_vld_ff  <= 1'b0;
         cnt_ff     <= '0;
         free_ff    <= '0;
         msize_ff   <= '0;
         fit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         iss_act_ff <= iss_act_in;
         ev_vld_ff  <= ev_vld_in;
         cnt_ff     <= cnt_in;
         free_ff    <= free_in;
         if (csr_we) begin
            case (cra_pkg::csr_index_type'(csr_index))
               cra_pkg::CSR_MEMORY_SIZE: msize_ff <= csr_wdata;
               cra_pkg::CSR_FIT_MODE:    fit_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/cra_checker.sv @@
`default_nettype none

module cra_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire cra_pkg::rsp_type rsp_data
);

   // one transaction in flight: no request taken while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request side open while response pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after accepting a request");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != cra_pkg::STS_OK) |->
         (rsp_data.block_start == '0 && rsp_data.block_end == '0))
      else $error("failed transaction reports an address range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response dropped or changed while stalled");

endmodule

bind contiguous_region_allocator_core cra_checker u_cra_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
